@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Expects clk and arst_n in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ hw/rtl/btff_pkg.sv @@
// Package for the boundary-tag first-fit allocator: heap geometry, field widths,
// sequencer states, status codes and reset image of the heap. No dependencies.
package btff_pkg;

	localparam int unsigned HEAP_BYTES  = 4096;
	localparam int unsigned HEAP_WORDS  = HEAP_BYTES / 4;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned ADDR_W      = WORD_W + 2;
	localparam int unsigned IDX_W       = $clog2(HEAP_WORDS);
	localparam int unsigned WALK_W      = $clog2(HEAP_WORDS + 1);

	localparam int unsigned REQ_W       = 13;
	localparam int unsigned OFF_W       = 12;
	localparam int unsigned STAT_W      = 2;
	localparam int unsigned NEED_W      = REQ_W + 1;
	localparam int unsigned IN_W        = ((REQ_W + OFF_W + 7) / 8) * 8;
	localparam int unsigned OUT_W       = ((OFF_W + 7) / 8) * 8;

	localparam int unsigned DWORD_BYTES = 8;
	localparam int unsigned MIN_BLOCK   = 16;
	localparam int unsigned TOTAL_BYTES = (HEAP_BYTES / DWORD_BYTES) * DWORD_BYTES;
	localparam int unsigned FREE_BYTES  = TOTAL_BYTES - MIN_BLOCK;
	localparam int unsigned FOOT_IDX    = (TOTAL_BYTES - 8) / 4;
	localparam int unsigned EPI_IDX     = (TOTAL_BYTES - 4) / 4;

	localparam logic [WORD_W-1:0] FLAG_BITS = WORD_W'(7);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_ZERO  = 2'd1,
		STAT_NOFIT = 2'd2
	} status_t;

	typedef enum logic [5:0] {
		ST_CLEAR, ST_IDLE, ST_FIN,
		ST_A0, ST_W0, ST_W1, ST_K0, ST_K1, ST_RET_P,
		ST_G_HEAD, ST_G_RD, ST_G_FOOT,
		ST_F0, ST_F1,
		ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
		ST_N0, ST_N1, ST_N2, ST_N3, ST_N4, ST_N5, ST_N6,
		ST_B0, ST_B1, ST_B2, ST_B3
	} state_t;

	function automatic logic signed [ADDR_W-1:0] zext(input logic [WORD_W-1:0] v);
		return $signed({{(ADDR_W - WORD_W){1'b0}}, v});
	endfunction

	// heap word at reset: padding, prologue, one free block, epilogue
	function automatic logic [WORD_W-1:0] init_word(input logic [IDX_W-1:0] idx);
		logic [WORD_W-1:0] w;
		w = '0;
		if (idx == IDX_W'(1) || idx == IDX_W'(2))
			w = WORD_W'(DWORD_BYTES) | WORD_W'(1);
		if (idx == IDX_W'(3))
			w = WORD_W'(FREE_BYTES);
		if (idx == IDX_W'(FOOT_IDX))
			w = WORD_W'(FREE_BYTES);
		if (idx == IDX_W'(EPI_IDX))
			w = WORD_W'(1);
		return w;
	endfunction

endpackage

@@ hw/rtl/boundary_tag_first_fit_allocator_unit.sv @@
// Top level of the boundary-tag first-fit allocator: heap memory, one shared adder
// and the sequencer that walks, splits and merges blocks. Uses btff_pkg, assert_macros.svh.
//
//  channel   dir  fields
//  s_*       in   tuser: operation; tdata: request_size, block_offset
//  m_*       out  tuser: status; tdata: result_offset
//
// After reset a clearing pass writes the heap image, all HEAP_BYTES/4 (1024) words, no beats taken.
// Allocate: the walk reads one header per block visited through the single memory read port.
// One beat is in work at a time; a new beat is taken while a result waits in the output register.
// Reset is asynchronous, active low, and clears the sequencer and the output valid.
`include "assert_macros.svh"

module boundary_tag_first_fit_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [btff_pkg::IN_W-1:0]   s_tdata,   // request_size [12:0], block_offset [24:13]
	input  logic                        s_tuser,   // operation
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [btff_pkg::OUT_W-1:0]  m_tdata,   // result_offset [11:0]
	output logic [btff_pkg::STAT_W-1:0] m_tuser    // status
);
	import btff_pkg::*;

	localparam logic signed [ADDR_W-1:0] HEAP_LIMIT  = ADDR_W'(HEAP_WORDS * 4);
	localparam logic signed [ADDR_W-1:0] MIN_BLOCK_A = ADDR_W'(MIN_BLOCK);

	state_t                    state_q, state_d, ret_q;
	logic [IDX_W-1:0]          clr_q;
	logic                      m_tvalid_q;
	logic [OFF_W-1:0]          m_off_q, res_off_q;
	status_t                   m_st_q, res_st_q;

	logic signed [ADDR_W-1:0]  p_q, t_q, u_q;
	logic [WORD_W-1:0]         tv_q, sz_q, sbh_q, snext_q;
	logic [NEED_W-1:0]         need_q;
	logic [REQ_W-1:0]          req_q;
	logic [WALK_W-1:0]         walk_q;
	logic                      pa_q;

	logic [WORD_W-1:0]         heap_q [HEAP_WORDS];
	logic [WORD_W-1:0]         mem_rdata_q;
	logic                      rd_ok_q;

	logic signed [ADDR_W-1:0]  alu_a, alu_b, alu_kx, alu_y, wr_addr;
	logic signed [4:0]         alu_k;
	logic                      rd_en, wr_en, wr_use_u, rd_ok, wr_ok;
	logic                      mem_we;
	logic [IDX_W-1:0]          mem_widx;
	logic [WORD_W-1:0]         mem_wdata;
	logic [WORD_W-1:0]         rword, rsize;
	logic                      rused, walk_cap, walk_end, fit, split, out_free;

	// shared adder
	assign alu_kx  = {{(ADDR_W - 5){alu_k[4]}}, alu_k};
	assign alu_y   = alu_a + alu_b + alu_kx;
	assign wr_addr = wr_use_u ? u_q : alu_y;

	assign rd_ok = !alu_y[ADDR_W-1] && (alu_y < HEAP_LIMIT);
	assign wr_ok = !wr_addr[ADDR_W-1] && (wr_addr < HEAP_LIMIT);

	assign rword = rd_ok_q ? mem_rdata_q : '0;
	assign rsize = rword & ~FLAG_BITS;
	assign rused = rword[0];

	assign walk_cap = (walk_q == WALK_W'(HEAP_WORDS));
	assign walk_end = walk_cap || (rsize == '0);
	assign fit      = !rused && (WORD_W'(need_q) <= rsize);
	assign split    = alu_y >= MIN_BLOCK_A;
	assign out_free = !m_tvalid_q || m_tready;

	assign mem_we    = (state_q == ST_CLEAR) ? 1'b1 : (wr_en && wr_ok);
	assign mem_widx  = (state_q == ST_CLEAR) ? clr_q : wr_addr[IDX_W+1:2];
	assign mem_wdata = (state_q == ST_CLEAR) ? init_word(clr_q) : tv_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			heap_q[mem_widx] <= mem_wdata;
		mem_rdata_q <= heap_q[alu_y[IDX_W+1:2]];
		rd_ok_q     <= rd_en && rd_ok;
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		alu_a    = p_q;
		alu_b    = '0;
		alu_k    = '0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_use_u = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_A0: begin
				alu_a = zext(WORD_W'(req_q));
				alu_k = 5'sd15;
			end
			ST_W0, ST_F0, ST_M4, ST_N0: begin
				alu_k = -5'sd4;
				rd_en = 1'b1;
			end
			ST_W1, ST_M5: alu_b = zext(rsize);
			ST_K0: begin
				alu_a = zext(sz_q);
				alu_b = -zext(WORD_W'(need_q));
			end
			ST_K1: alu_b = zext(WORD_W'(need_q));
			ST_G_HEAD, ST_N4, ST_B2: begin
				alu_a = t_q;
				alu_k = -5'sd4;
				wr_en = 1'b1;
			end
			ST_G_RD, ST_M2: begin
				alu_a = t_q;
				alu_k = -5'sd4;
				rd_en = 1'b1;
			end
			ST_G_FOOT: begin
				alu_a = t_q;
				alu_b = zext(rsize);
				alu_k = -5'sd8;
				wr_en = 1'b1;
			end
			ST_M0, ST_N2, ST_N5: begin
				alu_k = -5'sd8;
				rd_en = 1'b1;
			end
			ST_M1, ST_N3, ST_N6: alu_b = -zext(rsize);
			ST_M3: begin
				alu_a = t_q;
				alu_b = zext(rsize);
				alu_k = -5'sd8;
				rd_en = 1'b1;
			end
			ST_M6: begin
				alu_a = u_q;
				alu_k = -5'sd4;
				rd_en = 1'b1;
			end
			ST_M7: begin
				alu_a = zext(sz_q);
				alu_b = pa_q ? zext(rsize) : zext(sbh_q);
			end
			ST_N1: begin
				alu_b = zext(rsize);
				alu_k = -5'sd8;
				wr_en = 1'b1;
			end
			ST_B0: begin
				alu_a = u_q;
				alu_b = zext(snext_q);
				alu_k = -5'sd8;
				rd_en = 1'b1;
			end
			ST_B1: begin
				alu_a = zext(tv_q);
				alu_b = zext(rsize);
			end
			ST_B3: begin
				wr_en    = 1'b1;
				wr_use_u = 1'b1;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == IDX_W'(HEAP_WORDS - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (s_tvalid) state_d = (s_tuser == OP_FREE) ? ST_F0 : ST_A0;
			ST_A0:     state_d = (req_q == '0) ? ST_FIN : ST_W0;
			ST_W0:     state_d = ST_W1;
			ST_W1:     state_d = walk_end ? ST_FIN : (fit ? ST_K0 : ST_W0);
			ST_K0:     state_d = ST_G_HEAD;
			ST_K1:     state_d = ST_G_HEAD;
			ST_RET_P:  state_d = ST_FIN;
			ST_G_HEAD: state_d = ST_G_RD;
			ST_G_RD:   state_d = ST_G_FOOT;
			ST_G_FOOT: state_d = ret_q;
			ST_F0:     state_d = ST_F1;
			ST_F1:     state_d = ST_G_HEAD;
			ST_M0:     state_d = ST_M1;
			ST_M1:     state_d = ST_M2;
			ST_M2:     state_d = ST_M3;
			ST_M3:     state_d = ST_M4;
			ST_M4:     state_d = ST_M5;
			ST_M5:     state_d = ST_M6;
			ST_M6:     state_d = ST_M7;
			ST_M7: begin
				if (pa_q && rused)
					state_d = ST_RET_P;
				else if (pa_q)
					state_d = ST_G_HEAD;
				else if (rused)
					state_d = ST_N0;
				else
					state_d = ST_B0;
			end
			ST_N0:     state_d = ST_N1;
			ST_N1:     state_d = ST_N2;
			ST_N2:     state_d = ST_N3;
			ST_N3:     state_d = ST_N4;
			ST_N4:     state_d = ST_N5;
			ST_N5:     state_d = ST_N6;
			ST_N6:     state_d = ST_FIN;
			ST_B0:     state_d = ST_B1;
			ST_B1:     state_d = ST_B2;
			ST_B2:     state_d = ST_B3;
			ST_B3:     state_d = ST_N5;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + IDX_W'(1);
			if (state_q == ST_FIN && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_tvalid) begin
				req_q <= s_tdata[REQ_W-1:0];
				p_q   <= zext(WORD_W'(s_tdata[REQ_W+OFF_W-1:REQ_W]));
			end
			ST_A0: begin
				need_q    <= (req_q <= REQ_W'(DWORD_BYTES)) ? NEED_W'(MIN_BLOCK)
				             : (alu_y[NEED_W-1:0] & ~NEED_W'(7));
				p_q       <= zext(WORD_W'(DWORD_BYTES));
				walk_q    <= '0;
				res_off_q <= '0;
				res_st_q  <= STAT_ZERO;
			end
			ST_W1: begin
				if (walk_end) begin
					res_off_q <= '0;
					res_st_q  <= STAT_NOFIT;
				end else if (fit) begin
					sz_q <= rsize;
				end else begin
					p_q    <= alu_y;
					walk_q <= walk_q + WALK_W'(1);
				end
			end
			ST_K0: begin
				t_q <= p_q;
				if (split) begin
					tv_q  <= WORD_W'(need_q) | WORD_W'(1);
					sz_q  <= alu_y[WORD_W-1:0];
					ret_q <= ST_K1;
				end else begin
					tv_q  <= sz_q | WORD_W'(1);
					ret_q <= ST_RET_P;
				end
			end
			ST_K1: begin
				t_q   <= alu_y;
				tv_q  <= sz_q;
				ret_q <= ST_RET_P;
			end
			ST_RET_P: begin
				res_off_q <= p_q[OFF_W-1:0];
				res_st_q  <= STAT_OK;
			end
			ST_F1: begin
				tv_q  <= rsize;
				t_q   <= p_q;
				ret_q <= ST_M0;
			end
			ST_M1, ST_N3: t_q <= alu_y;
			ST_M3: sbh_q <= rsize;
			ST_M4: pa_q <= rused;
			ST_M5: begin
				sz_q <= rsize;
				u_q  <= alu_y;
			end
			ST_M7: begin
				snext_q <= rsize;
				tv_q    <= alu_y[WORD_W-1:0];
				ret_q   <= ST_RET_P;
				if (pa_q)
					t_q <= p_q;
			end
			ST_N6: begin
				res_off_q <= alu_y[OFF_W-1:0];
				res_st_q  <= STAT_OK;
			end
			ST_B0: u_q <= alu_y;
			ST_B1: tv_q <= alu_y[WORD_W-1:0];
			ST_FIN: if (out_free) begin
				m_off_q <= res_off_q;
				m_st_q  <= res_st_q;
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W - OFF_W){1'b0}}, m_off_q};
	assign m_tuser  = m_st_q;

	`ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, state_q != ST_IDLE, "idle after beat")
	`ASSERT_IMPL(a_no_write_idle, state_q == ST_IDLE, !mem_we, "heap written while idle")
	`ASSERT_NEXT(a_walk_bound, state_q == ST_W1 && walk_cap, state_q == ST_FIN, "walk overrun")
	`ASSERT_NEXT(a_result_loaded, state_q == ST_FIN && out_free, m_tvalid, "result not presented")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for boundary_tag_first_fit_allocator_unit (uses btff_pkg): a directed
// table, then random alloc/free traffic, checked against a behavioural heap model or the table.
module testbench;
	import btff_pkg::*;

	typedef logic [63:0] addr_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		status_t          stat;
	} outcome_t;

	typedef struct packed {
		logic             op;
		logic [REQ_W-1:0] req;
		logic [OFF_W-1:0] off;
		bit               fixed;
		logic [OFF_W-1:0] want_off;
		status_t          want_stat;
	} probe_t;

	localparam int unsigned WORD_BYTES   = 4;
	localparam int unsigned CYCLE_LIMIT  = 5_000_000;
	localparam int unsigned N_RANDOM     = 800;
	localparam int unsigned NOISE_FROM   = 740;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned HOLD_AFTER   = 120;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic [STAT_W-1:0] m_tuser;

	logic [WORD_W-1:0] heap_img [HEAP_WORDS];
	outcome_t          pending_q [$];
	logic [OFF_W-1:0]  live_q [$];
	int unsigned       n_taken;
	int unsigned       n_bad;
	int unsigned       cycles;
	bit                sender_calm;

	// op, request, offset, fixed, expected offset, expected status
	probe_t script [24] = '{
		'{OP_ALLOC, 13'd0,    12'd4095, 1'b1, 12'd0,  STAT_ZERO},
		'{OP_ALLOC, 13'd4096, 12'd0,    1'b1, 12'd0,  STAT_NOFIT},
		'{OP_ALLOC, 13'd8191, 12'd4095, 1'b1, 12'd0,  STAT_NOFIT},
		'{OP_ALLOC, 13'd1,    12'd0,    1'b1, 12'd16, STAT_OK},
		'{OP_ALLOC, 13'd8,    12'd0,    1'b1, 12'd32, STAT_OK},
		'{OP_ALLOC, 13'd9,    12'd0,    1'b1, 12'd48, STAT_OK},
		'{OP_ALLOC, 13'd4016, 12'd0,    1'b0, 12'd0,  STAT_OK},
		'{OP_ALLOC, 13'd1,    12'd0,    1'b1, 12'd0,  STAT_NOFIT},
		'{OP_FREE,  13'd8191, 12'd32,   1'b0, 12'd0,  STAT_OK},
		'{OP_FREE,  13'd0,    12'd48,   1'b0, 12'd0,  STAT_OK},
		'{OP_FREE,  13'd0,    12'd72,   1'b0, 12'd0,  STAT_OK},
		'{OP_FREE,  13'd8191, 12'd16,   1'b0, 12'd0,  STAT_OK},
		'{OP_FREE,  13'd0,    12'd16,   1'b0, 12'd0,  STAT_OK},
		'{OP_ALLOC, 13'd4072, 12'd0,    1'b0, 12'd0,  STAT_OK},
		'{OP_ALLOC, 13'd1,    12'd0,    1'b1, 12'd0,  STAT_NOFIT},
		'{OP_FREE,  13'd0,    12'd16,   1'b0, 12'd0,  STAT_OK},
		'{OP_ALLOC, 13'd4057, 12'd4095, 1'b0, 12'd0,  STAT_OK},
		'{OP_FREE,  13'd0,    12'd16,   1'b0, 12'd0,  STAT_OK},
		'{OP_ALLOC, 13'd24,   12'd0,    1'b0, 12'd0,  STAT_OK},
		'{OP_ALLOC, 13'd100,  12'd0,    1'b0, 12'd0,  STAT_OK},
		'{OP_ALLOC, 13'd1,    12'd0,    1'b0, 12'd0,  STAT_OK},
		'{OP_FREE,  13'd0,    12'd16,   1'b0, 12'd0,  STAT_OK},
		'{OP_FREE,  13'd0,    12'd160,  1'b0, 12'd0,  STAT_OK},
		'{OP_FREE,  13'd0,    12'd48,   1'b0, 12'd0,  STAT_OK}
	};

	boundary_tag_first_fit_allocator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// heap model; out-of-range reads give zero, out-of-range writes are dropped
	function automatic logic [WORD_W-1:0] peek(addr_t a);
		addr_t idx;
		idx = a >> 2;
		if (idx >= addr_t'(HEAP_WORDS))
			return '0;
		return heap_img[idx[IDX_W-1:0]];
	endfunction

	function automatic void poke(addr_t a, logic [WORD_W-1:0] v);
		addr_t idx;
		idx = a >> 2;
		if (idx < addr_t'(HEAP_WORDS))
			heap_img[idx[IDX_W-1:0]] = v;
	endfunction

	function automatic logic [WORD_W-1:0] span(addr_t a);
		return peek(a) & ~FLAG_BITS;
	endfunction

	function automatic logic taken(addr_t a);
		logic [WORD_W-1:0] w;
		w = peek(a);
		return w[0];
	endfunction

	function automatic addr_t hdr(addr_t p);
		return p - addr_t'(WORD_BYTES);
	endfunction

	function automatic addr_t ftr(addr_t p);
		return p + addr_t'(span(hdr(p))) - addr_t'(DWORD_BYTES);
	endfunction

	function automatic addr_t nxt(addr_t p);
		return p + addr_t'(span(p - addr_t'(WORD_BYTES)));
	endfunction

	function automatic addr_t prv(addr_t p);
		return p - addr_t'(span(p - addr_t'(DWORD_BYTES)));
	endfunction

	// footer position follows the header just written
	function automatic void stamp(addr_t p, logic [WORD_W-1:0] sz, logic used);
		poke(hdr(p), sz | WORD_W'(used));
		poke(ftr(p), sz | WORD_W'(used));
	endfunction

	function automatic addr_t coalesce(addr_t p);
		logic              pa;
		logic              na;
		logic [WORD_W-1:0] sz;
		addr_t             nf;
		addr_t             ph;
		pa = taken(ftr(prv(p)));
		na = taken(hdr(nxt(p)));
		sz = span(hdr(p));
		if (pa && na)
			return p;
		if (pa) begin
			sz = sz + span(hdr(nxt(p)));
			poke(hdr(p), sz);
			poke(ftr(p), sz);
			return p;
		end
		if (na) begin
			sz = sz + span(hdr(prv(p)));
			poke(ftr(p), sz);
			poke(hdr(prv(p)), sz);
			return prv(p);
		end
		nf = ftr(nxt(p));
		ph = hdr(prv(p));
		sz = sz + span(ph) + span(nf);
		poke(ph, sz);
		poke(nf, sz);
		return prv(p);
	endfunction

	function automatic void carve(addr_t p, logic [WORD_W-1:0] need);
		logic [WORD_W-1:0] have;
		have = span(hdr(p));
		if (have - need >= WORD_W'(MIN_BLOCK)) begin
			stamp(p, need, 1'b1);
			stamp(nxt(p), have - need, 1'b0);
		end else begin
			stamp(p, have, 1'b1);
		end
	endfunction

	function automatic void heap_reset();
		foreach (heap_img[i])
			heap_img[i] = '0;
		poke(addr_t'(4), WORD_W'(DWORD_BYTES) | 1);
		poke(addr_t'(8), WORD_W'(DWORD_BYTES) | 1);
		poke(addr_t'(12), WORD_W'(FREE_BYTES));
		poke(addr_t'(12 + FREE_BYTES - WORD_BYTES), WORD_W'(FREE_BYTES));
		poke(addr_t'(12 + FREE_BYTES), WORD_W'(1));
	endfunction

	function automatic outcome_t heap_apply(logic op, logic [REQ_W-1:0] req,
		logic [OFF_W-1:0] off);
		outcome_t          r;
		logic [WORD_W-1:0] need;
		addr_t             p;
		int unsigned       n;
		r.off  = '0;
		r.stat = STAT_OK;
		if (op == OP_FREE) begin
			p = addr_t'(off);
			stamp(p, span(hdr(p)), 1'b0);
			p = coalesce(p);
			r.off = p[OFF_W-1:0];
			return r;
		end
		if (req == '0) begin
			r.stat = STAT_ZERO;
			return r;
		end
		if (req <= REQ_W'(DWORD_BYTES))
			need = WORD_W'(MIN_BLOCK);
		else
			need = (WORD_W'(req) + WORD_W'(2 * DWORD_BYTES - 1)) / WORD_W'(DWORD_BYTES)
				* WORD_W'(DWORD_BYTES);
		p = addr_t'(DWORD_BYTES);
		for (n = 0; n < HEAP_WORDS && span(hdr(p)) > 0; n++) begin
			if (!taken(hdr(p)) && need <= span(hdr(p))) begin
				carve(p, need);
				r.off = p[OFF_W-1:0];
				return r;
			end
			p = nxt(p);
		end
		r.stat = STAT_NOFIT;
		return r;
	endfunction

	function automatic void log_beat(probe_t b);
		outcome_t r;
		outcome_t w;
		r = heap_apply(b.op, b.req, b.off);
		w = r;
		if (b.fixed) begin
			w.off  = b.want_off;
			w.stat = b.want_stat;
		end
		pending_q.push_back(w);
		if (b.op == OP_FREE) begin
			for (int i = live_q.size() - 1; i >= 0; i--)
				if (live_q[i] == b.off)
					live_q.delete(i);
		end else if (r.stat == STAT_OK) begin
			live_q.push_back(r.off);
		end
		n_taken++;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// random allocs and mostly valid frees of live blocks; in the noisy tail a third free any offset
	function automatic probe_t draw_item(bit noisy);
		probe_t      b;
		int unsigned r;
		int unsigned pa;
		b     = '0;
		b.req = REQ_W'($urandom);
		b.off = OFF_W'($urandom);
		pa = (live_q.size() == 0) ? 100 : ((live_q.size() > 40) ? 30 : 55);
		if ($urandom_range(0, 99) < pa) begin
			b.op = OP_ALLOC;
			r = $urandom_range(0, 99);
			if (r < 4)
				b.req = '0;
			else if (r < 10)
				b.req = REQ_W'($urandom_range(1, 8));
			else if (r < 60)
				b.req = REQ_W'($urandom_range(9, 128));
			else if (r < 85)
				b.req = REQ_W'($urandom_range(129, 600));
			else if (r < 95)
				b.req = REQ_W'($urandom_range(601, 4096));
			else
				b.req = REQ_W'($urandom_range(4097, 8191));
		end else begin
			b.op = OP_FREE;
			if (!(noisy && $urandom_range(0, 2) == 0))
				b.off = live_q[$urandom_range(0, live_q.size() - 1)];
		end
		return b;
	endfunction

	task automatic offer(probe_t b);
		int unsigned gap;
		gap = sender_calm ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= b.op;
		s_tdata  <= IN_W'({b.off, b.req});
		do
			@(posedge clk);
		while (!s_tready);
		log_beat(b);
		@(negedge clk);
	endtask

	task automatic note_bad(string what, outcome_t w);
		n_bad++;
		if (n_bad <= 10)
			$display("%0t: %s: expected offset %0d status %0d, got offset %0d status %0d",
				$time, what, w.off, w.stat, m_tdata[OFF_W-1:0], m_tuser);
	endtask

	initial begin
		s_tvalid    = 1'b0;
		s_tuser     = 1'b0;
		s_tdata     = '0;
		arst_n      = 1'b0;
		n_taken     = 0;
		n_bad       = 0;
		cycles      = 0;
		sender_calm = 1'b0;
		heap_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (script[i])
			offer(script[i]);
		for (int unsigned i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 39) == 0)
				sender_calm = !sender_calm;
			offer(draw_item(i >= NOISE_FROM));
		end
		s_tvalid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_bad == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// random m_tready gaps, plus one long hold-off that fills the block and stalls its input
	initial begin
		int unsigned n;
		bit          calm;
		bit          held;
		m_tready = 1'b0;
		calm     = 1'b0;
		held     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && n_taken >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if ($urandom_range(0, 49) == 0)
				calm = !calm;
			n = calm ? 0 : idle_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				w = '0;
				note_bad("unexpected beat", w);
			end else begin
				w = pending_q.pop_front();
				if (m_tdata[OFF_W-1:0] !== w.off || m_tuser !== w.stat)
					note_bad("mismatch", w);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule
